// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, gated by reset.
`define RTPM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked invariant, gated by reset.
`define RTPM_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// ===== hdl/rtpm_pkg.sv =====
`timescale 1ns / 1ps

package rtpm_pkg;

    localparam int CMD_W    = 2;
    localparam int PLEN_W   = 7;
    localparam int CLASS_W  = 8;
    localparam int HOP_W    = 16;
    localparam int STATUS_W = 2;

    // slave tdata layout
    localparam int IN_CMD_LO   = 0;
    localparam int IN_ADDR_LO  = 2;
    localparam int IN_ADDR_W   = 64;
    localparam int IN_PLEN_LO  = 66;
    localparam int IN_CLASS_LO = 73;
    localparam int IN_HOP_LO   = 81;
    localparam int S_TDATA_W   = 104;

    // master tdata layout
    localparam int M_TDATA_W = 24;
    localparam int M_PAD_W   = M_TDATA_W - STATUS_W - HOP_W;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    localparam logic [CLASS_W-1:0] CLASS_CEILING = 8'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_RESP
    } state_t;

endpackage

// ===== hdl/route_table_prefix_match.sv =====
`timescale 1ns / 1ps
// Ordered route table with prefix lookup. Each transfer on the slave
// stream is one command (add, remove, lookup) and yields exactly one transfer
// on the master stream with a status and a next hop. Routes live in a single
// port-pair RAM (one write, one registered read per cycle) and every command
// that searches walks it one entry per clock through one shared compare unit.
// A lookup keeps the entry with the lowest route_type whose prefix matches,
// and within that type the longest prefix; on a tie the earlier entry stays.
// Add appends at the fill count (status full when no room is left) and unused
// codes answer with a miss; both go straight to the response state. Lookup and
// remove issue the first read, compare every valid entry in order, see the end
// of the table, then pass through the response state back to idle. A remove
// that hits at index f scans to f and then moves every later entry down one
// place, one per clock. s_tready is high only between commands; a finished
// result sits in the master output register so the next command can be taken
// while it waits. A result that finds that register still full holds the block
// in its response state until the waiting transfer completes. Table contents
// need no clearing after reset: only entries below the fill count are ever read.

`include "assert_macros.svh"

module route_table_prefix_match #(
    parameter int MAX_ROUTES = 32,
    parameter int ADDR_BITS  = 64,
    parameter int HOP_BITS   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cmd[1:0], address[65:2], pfx_len[72:66], route_type[80:73],
    // hop_in[96:81], zero fill[103:97]
    input  logic [rtpm_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[1:0], hop_out[17:2], zero fill[23:18]
    output logic [rtpm_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(MAX_ROUTES + 1);
    localparam int IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int P_LO  = ADDR_BITS;
    localparam int C_LO  = P_LO + rtpm_pkg::PLEN_W;
    localparam int H_LO  = C_LO + rtpm_pkg::CLASS_W;
    localparam int ENT_W = H_LO + HOP_BITS;

    // input field unpack
    logic [rtpm_pkg::CMD_W-1:0]   in_cmd;
    logic [ADDR_BITS-1:0]         in_addr;
    logic [rtpm_pkg::PLEN_W-1:0]  in_plen;
    logic [rtpm_pkg::CLASS_W-1:0] in_class;
    logic [31:0]                  in_hop_wide;

    assign in_cmd      = s_tdata[rtpm_pkg::IN_CMD_LO +: rtpm_pkg::CMD_W];
    assign in_addr     = s_tdata[rtpm_pkg::IN_ADDR_LO +: ADDR_BITS];
    assign in_plen     = s_tdata[rtpm_pkg::IN_PLEN_LO +: rtpm_pkg::PLEN_W];
    assign in_class    = s_tdata[rtpm_pkg::IN_CLASS_LO +: rtpm_pkg::CLASS_W];
    assign in_hop_wide = 32'(s_tdata[rtpm_pkg::IN_HOP_LO +: rtpm_pkg::HOP_W]);

    // route RAM: {hop, class, prefix, address}
    logic [ENT_W-1:0] route_mem [MAX_ROUTES];
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic [ENT_W-1:0] rd_data_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [ENT_W-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            route_mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= route_mem[rd_idx];
        end
    end

    // control state
    rtpm_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;       // next entry to read
    logic             pv_reg, pv_next;         // rd_data_reg holds a live entry
    logic             found_reg, found_next;
    logic             m_valid_reg, m_valid_next;

    // payload
    logic [rtpm_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [ADDR_BITS-1:0]          addr_reg, addr_next;
    logic [rtpm_pkg::PLEN_W-1:0]   plen_reg, plen_next;
    logic [IDX_W-1:0]              cmp_idx_reg, cmp_idx_next;
    logic [rtpm_pkg::CLASS_W-1:0]  best_class_reg, best_class_next;
    logic [rtpm_pkg::PLEN_W-1:0]   best_len_reg, best_len_next;
    logic [HOP_BITS-1:0]           best_hop_reg, best_hop_next;
    logic [rtpm_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [rtpm_pkg::HOP_W-1:0]    res_hop_reg, res_hop_next;
    logic [rtpm_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    // entry being compared
    logic [ADDR_BITS-1:0]         e_addr;
    logic [rtpm_pkg::PLEN_W-1:0]  e_plen;
    logic [rtpm_pkg::CLASS_W-1:0] e_class;
    logic [HOP_BITS-1:0]          e_hop;
    logic [31:0]                  best_hop_wide;

    assign e_addr        = rd_data_reg[ADDR_BITS-1:0];
    assign e_plen        = rd_data_reg[P_LO +: rtpm_pkg::PLEN_W];
    assign e_class       = rd_data_reg[C_LO +: rtpm_pkg::CLASS_W];
    assign e_hop         = rd_data_reg[H_LO +: HOP_BITS];
    assign best_hop_wide = 32'(best_hop_reg);

    // shared compare unit
    logic [ADDR_BITS-1:0] addr_diff;
    logic                 prefix_hit;
    logic                 lk_elig;
    logic                 rm_match;

    assign addr_diff = e_addr ^ addr_reg;

    // top e_plen bits must agree
    always_comb
    begin
        prefix_hit = 1'b1;
        for (int k = 0; k < ADDR_BITS; k++)
        begin
            if ((k + int'(e_plen) >= ADDR_BITS) && addr_diff[k])
            begin
                prefix_hit = 1'b0;
            end
        end
    end

    assign lk_elig = (e_class <= best_class_reg)
                   && !((e_class == best_class_reg) && found_reg && (e_plen <= best_len_reg))
                   && (e_plen <= rtpm_pkg::PLEN_W'(ADDR_BITS))
                   && prefix_hit;

    assign rm_match = (e_addr == addr_reg) && (e_plen == plen_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rtpm_pkg::ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            pv_reg      <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            pv_reg      <= pv_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        addr_reg       <= addr_next;
        plen_reg       <= plen_next;
        cmp_idx_reg    <= cmp_idx_next;
        best_class_reg <= best_class_next;
        best_len_reg   <= best_len_next;
        best_hop_reg   <= best_hop_next;
        res_status_reg <= res_status_next;
        res_hop_reg    <= res_hop_next;
        m_data_reg     <= m_data_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pv_next         = pv_reg;
        found_next      = found_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        plen_next       = plen_reg;
        cmp_idx_next    = cmp_idx_reg;
        best_class_next = best_class_reg;
        best_len_next   = best_len_reg;
        best_hop_next   = best_hop_reg;
        res_status_next = res_status_reg;
        res_hop_next    = res_hop_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        s_tready = (state_reg == rtpm_pkg::ST_IDLE);
        rd_en    = 1'b0;
        rd_idx   = idx_reg[IDX_W-1:0];
        wr_en    = 1'b0;
        wr_idx   = count_reg[IDX_W-1:0];
        wr_data  = {in_hop_wide[HOP_BITS-1:0], in_class, in_plen, in_addr};

        // read issue, shared by scan and shift
        if ((state_reg == rtpm_pkg::ST_SCAN) || (state_reg == rtpm_pkg::ST_SHIFT))
        begin
            if (idx_reg < count_reg)
            begin
                rd_en        = 1'b1;
                pv_next      = 1'b1;
                cmp_idx_next = idx_reg[IDX_W-1:0];
                idx_next     = idx_reg + 1'b1;
            end
            else
            begin
                pv_next = 1'b0;
            end
        end

        unique case (state_reg)
            rtpm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next        = in_cmd;
                    addr_next       = in_addr;
                    plen_next       = in_plen;
                    idx_next        = '0;
                    pv_next         = 1'b0;
                    found_next      = 1'b0;
                    best_class_next = rtpm_pkg::CLASS_CEILING;
                    best_len_next   = '0;
                    best_hop_next   = '0;
                    res_hop_next    = '0;
                    priority if (in_cmd == rtpm_pkg::CMD_ADD)
                    begin
                        if (count_reg < CNT_W'(MAX_ROUTES))
                        begin
                            wr_en           = 1'b1;
                            count_next      = count_reg + 1'b1;
                            res_status_next = rtpm_pkg::ST_OK;
                        end
                        else
                        begin
                            res_status_next = rtpm_pkg::ST_FULL;
                        end
                        state_next = rtpm_pkg::ST_RESP;
                    end
                    else if ((in_cmd == rtpm_pkg::CMD_REMOVE)
                             || (in_cmd == rtpm_pkg::CMD_LOOKUP))
                    begin
                        state_next = rtpm_pkg::ST_SCAN;
                    end
                    else
                    begin
                        res_status_next = rtpm_pkg::ST_MISS;
                        state_next      = rtpm_pkg::ST_RESP;
                    end
                end
            end

            rtpm_pkg::ST_SCAN:
            begin
                priority if (pv_reg && (cmd_reg == rtpm_pkg::CMD_REMOVE))
                begin
                    // first hit: start moving later entries down
                    if (rm_match)
                    begin
                        state_next = rtpm_pkg::ST_SHIFT;
                    end
                end
                else if (pv_reg)
                begin
                    if (lk_elig)
                    begin
                        found_next      = 1'b1;
                        best_class_next = e_class;
                        best_len_next   = e_plen;
                        best_hop_next   = e_hop;
                    end
                end
                else if (idx_reg >= count_reg)
                begin
                    res_status_next = found_reg ? rtpm_pkg::ST_OK : rtpm_pkg::ST_MISS;
                    res_hop_next    = found_reg ? best_hop_wide[rtpm_pkg::HOP_W-1:0] : '0;
                    state_next      = rtpm_pkg::ST_RESP;
                end
            end

            rtpm_pkg::ST_SHIFT:
            begin
                if (pv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_idx  = cmp_idx_reg - 1'b1;
                    wr_data = rd_data_reg;
                end
                else if (idx_reg >= count_reg)
                begin
                    count_next      = count_reg - 1'b1;
                    res_status_next = rtpm_pkg::ST_OK;
                    res_hop_next    = '0;
                    state_next      = rtpm_pkg::ST_RESP;
                end
            end

            rtpm_pkg::ST_RESP:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{rtpm_pkg::M_PAD_W{1'b0}}, res_hop_reg, res_status_reg};
                    state_next   = rtpm_pkg::ST_IDLE;
                end
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // fill count stays within the table
    `RTPM_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(MAX_ROUTES), "route count overflow")

    // a shift write never lands below entry zero
    `RTPM_ASSERT(a_shift_dst, (state_reg == rtpm_pkg::ST_SHIFT && pv_reg) |-> (cmp_idx_reg != '0), "shift write underflow")

    // an accepted add with room grows the table by one
    `RTPM_ASSERT(a_add_grow, (s_tvalid && s_tready && in_cmd == rtpm_pkg::CMD_ADD && count_reg < CNT_W'(MAX_ROUTES)) |=> (count_reg == $past(count_reg) + 1'b1), "add did not grow table")

endmodule
